FILE: rtl/utf8_stream_sanitizer_core_macros.svh
// Assertion macros for the UTF-8 stream sanitizer checker.
// Depends on nothing; included by the checker file only.
`ifndef UTF8_STREAM_SANITIZER_CORE_MACROS_SVH
`define UTF8_STREAM_SANITIZER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define U8S_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8s assertion failed");

// next-cycle implication, disabled during reset
`define U8S_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8s assertion failed");

`endif

FILE: rtl/u8s_pkg.sv
// Shared types, constants and byte classifiers for the UTF-8 stream sanitizer.
// Depends on nothing; imported by every design module of the block but the checker.
package u8s_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  typedef struct packed {
    logic       repl;
    logic       last;
    logic [7:0] data;
  } u8s_tok_t;

  typedef struct packed {
    logic     valid;
    u8s_tok_t tok;
  } u8s_push_t;

  function automatic logic is_cont(input logic [7:0] b);
    is_cont = (b & 8'hC0) == 8'h80;
  endfunction

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    if (b <= 8'h7F) begin
      lead_len = 3'd1;
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      lead_len = 3'd2;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      lead_len = 3'd3;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd0;
    end
  endfunction

  function automatic logic seq_ok(input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [7:0] b2, input logic [7:0] b3,
                                  input logic [2:0] len);
    logic ok;
    ok = 1'b1;
    if (len >= 3'd2 && !is_cont(b1)) ok = 1'b0;
    if (len >= 3'd3 && !is_cont(b2)) ok = 1'b0;
    if (len == 3'd4 && !is_cont(b3)) ok = 1'b0;
    if (len == 3'd3) begin
      if (b0 == 8'hE0 && b1 < 8'hA0) ok = 1'b0;
      if (b0 == 8'hED && b1 >= 8'hA0) ok = 1'b0;
    end
    if (len == 3'd4) begin
      if (b0 == 8'hF0 && b1 < 8'h90) ok = 1'b0;
      if (b0 == 8'hF4 && b1 > 8'h8F) ok = 1'b0;
    end
    seq_ok = ok;
  endfunction

endpackage

FILE: rtl/u8s_front.sv
// Front end: accepts input bytes, holds the unfinished sequence and scans it,
// emitting one token (byte or replacement) per cycle while the queue is ready. Depends on u8s_pkg.
module u8s_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic               in_tlast,
  input  logic               q_ready,
  output u8s_pkg::u8s_push_t push
);
  import u8s_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } st_t;

  st_t        st_r, st_nxt;
  logic [7:0] buf_r [4];
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] rem_r, rem_nxt;
  logic       eos_r, eos_nxt;
  logic       pend_vld_r, pend_vld_nxt;
  u8s_tok_t   pend_r, pend_nxt;
  logic       acc, shift;
  logic [2:0] len;
  logic       ok;

  assign acc       = in_tvalid && in_tready;
  assign in_tready = (st_r == ST_IDLE);
  assign len       = lead_len(buf_r[0]);
  assign ok        = seq_ok(buf_r[0], buf_r[1], buf_r[2], buf_r[3], len);

  always_comb begin
    st_nxt       = st_r;
    cnt_nxt      = cnt_r;
    rem_nxt      = rem_r;
    eos_nxt      = eos_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    shift        = 1'b0;
    push.valid   = 1'b0;
    push.tok     = pend_r;
    push.tok.last = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (acc) begin
          cnt_nxt = cnt_r + 3'd1;
          eos_nxt = in_tlast;
          rem_nxt = 2'd0;
          st_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (q_ready) begin
          if (rem_r != 2'd0 || (cnt_r != 3'd0 && len != 3'd0 && len <= cnt_r)) begin
            // emit a byte of a good sequence, start one, or replace a bad lead
            push.valid   = pend_vld_r;
            pend_vld_nxt = 1'b1;
            pend_nxt     = '{repl: 1'b0, last: 1'b0, data: buf_r[0]};
            shift        = 1'b1;
            cnt_nxt      = cnt_r - 3'd1;
            if (rem_r != 2'd0) begin
              rem_nxt = rem_r - 2'd1;
            end else if (!ok) begin
              pend_nxt.repl = 1'b1;
            end else begin
              rem_nxt = 2'(len - 3'd1);
            end
          end else if (cnt_r != 3'd0 && len == 3'd0) begin
            // bad lead: replace and drop
            push.valid   = pend_vld_r;
            pend_vld_nxt = 1'b1;
            pend_nxt     = '{repl: 1'b1, last: 1'b0, data: buf_r[0]};
            shift        = 1'b1;
            cnt_nxt      = cnt_r - 3'd1;
          end else begin
            // end of scan: flush pending token as last of run
            push.valid    = pend_vld_r;
            push.tok.last = 1'b1;
            pend_vld_nxt  = 1'b0;
            if (eos_r) cnt_nxt = 3'd0;
            st_nxt = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      cnt_r      <= 3'd0;
      rem_r      <= 2'd0;
      eos_r      <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      cnt_r      <= cnt_nxt;
      rem_r      <= rem_nxt;
      eos_r      <= eos_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    if (acc) begin
      buf_r[cnt_r[1:0]] <= in_tdata;
    end else if (shift) begin
      buf_r[0] <= buf_r[1];
      buf_r[1] <= buf_r[2];
      buf_r[2] <= buf_r[3];
    end
  end

endmodule

FILE: rtl/u8s_queue.sv
// Token queue between the front scanner and the back end output stage.
// Depends on u8s_pkg.
module u8s_queue #(
  parameter int unsigned DEPTH = u8s_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  u8s_pkg::u8s_push_t push,
  output logic               q_ready,
  output logic               q_valid,
  output u8s_pkg::u8s_tok_t  q_tok,
  input  logic               pop
);
  import u8s_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  u8s_tok_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               wr, rd;

  assign q_ready = (cnt_r != CNT_W'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_tok   = mem_r[rd_ptr_r];
  assign wr      = push.valid && q_ready;
  assign rd      = pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wr_ptr_r] <= push.tok;
  end

endmodule

FILE: rtl/u8s_back.sv
// Back end: pops tokens, expands replacements to EF BF BD and drives the
// registered output stream. Depends on u8s_pkg.
module u8s_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  u8s_pkg::u8s_tok_t q_tok,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast
);
  import u8s_pkg::*;

  typedef enum logic [2:0] {
    PH_HEAD = 3'b001,
    PH_MID  = 3'b010,
    PH_TAIL = 3'b100
  } ph_t;

  ph_t        phase_r, phase_nxt;
  logic       cur_last_r, cur_last_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] data_r, data_nxt;
  logic       last_r, last_nxt;
  logic       out_free;

  assign out_free   = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

  always_comb begin
    phase_nxt    = phase_r;
    cur_last_nxt = cur_last_r;
    vld_nxt      = vld_r;
    data_nxt     = data_r;
    last_nxt     = last_r;
    pop          = 1'b0;
    if (out_free) begin
      unique case (phase_r)
        PH_MID: begin
          vld_nxt   = 1'b1;
          data_nxt  = REPL_B1;
          last_nxt  = 1'b0;
          phase_nxt = PH_TAIL;
        end
        PH_TAIL: begin
          vld_nxt   = 1'b1;
          data_nxt  = REPL_B2;
          last_nxt  = cur_last_r;
          phase_nxt = PH_HEAD;
        end
        default: begin
          if (q_valid) begin
            pop     = 1'b1;
            vld_nxt = 1'b1;
            if (q_tok.repl) begin
              data_nxt     = REPL_B0;
              last_nxt     = 1'b0;
              cur_last_nxt = q_tok.last;
              phase_nxt    = PH_MID;
            end else begin
              data_nxt = q_tok.data;
              last_nxt = q_tok.last;
            end
          end else begin
            vld_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD;
      vld_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_last_r <= cur_last_nxt;
    data_r     <= data_nxt;
    last_r     <= last_nxt;
  end

endmodule

FILE: rtl/utf8_stream_sanitizer_core.sv
// Channel | dir | tdata               | tlast
// in_     | in  | [7:0] data_byte     | end_of_stream
// out_    | out | [7:0] out_byte      | last_in_run
// An input byte is taken only while the front end is idle; the front scanner then emits
// one token (passed byte or replacement) per byte it resolves, stalling on a full queue,
// and no further input byte is taken until it has closed the scan.
// A replacement token leaves the back end as three output beats.
// A full token queue stalls the scanner; a stalled output stalls the back end and so fills the queue.
// Reset clears held count, queue and output valid; held bytes need no clearing.
// Top level of the UTF-8 stream sanitizer. Depends on u8s_pkg, u8s_front,
// u8s_queue and u8s_back.
module utf8_stream_sanitizer_core #(
  parameter int unsigned QUEUE_DEPTH = u8s_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] data_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tlast
);
  import u8s_pkg::*;

  u8s_push_t push;
  u8s_tok_t  q_tok;
  logic      q_ready, q_valid, pop;

  u8s_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_ready   (q_ready),
    .push      (push)
  );

  u8s_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .q_ready (q_ready),
    .q_valid (q_valid),
    .q_tok   (q_tok),
    .pop     (pop)
  );

  u8s_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_tok      (q_tok),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: rtl/u8s_chk.sv
// Port-level checker for the UTF-8 stream sanitizer, bound to the top level.
// Depends on utf8_stream_sanitizer_core_macros.svh.
`include "utf8_stream_sanitizer_core_macros.svh"

module u8s_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  `U8S_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  `U8S_ASSERT_NOW(a_no_bad_byte, clk, rst_n, out_tvalid, out_tdata != 8'hC0 && out_tdata != 8'hC1 && out_tdata < 8'hF5)
  `U8S_ASSERT_NEXT(a_scan_after_take, clk, rst_n, in_tvalid && in_tready, !in_tready)

endmodule

bind utf8_stream_sanitizer_core u8s_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

FILE: test/utf8_stream_sanitizer_core_test.sv
`timescale 1ns / 100ps
// Self-checking bench for utf8_stream_sanitizer_core: drives raw text bytes, predicts
// the sanitized byte stream and compares every output beat. Depends on u8s_pkg.
module utf8_stream_sanitizer_core_test;
  import u8s_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RANDOM_ITEMS = 300;

  typedef struct {
    logic [7:0] value;
    logic       last_flag;
  } clean_beat_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  clean_beat_t clean_q[$];
  logic [7:0]  pend_bytes[0:2];
  int unsigned pend_cnt = 0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned stall_left = 0;
  int unsigned sent = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;

  utf8_stream_sanitizer_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int unsigned pick_gap(bit on);
    int unsigned r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!rx_idle_on) begin
      out_tready <= 1'b1;
    end else begin
      stall_left <= pick_gap(1'b1);
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    clean_beat_t exp_beat;
    if (rst_n && out_tvalid && out_tready) begin
      if (clean_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected output byte %02h last %0b", $time, out_tdata, out_tlast);
      end else begin
        exp_beat = clean_q.pop_front();
        if (out_tdata !== exp_beat.value) begin
          errors++;
          $display("%0t: out_byte expected %02h got %02h", $time, exp_beat.value,
                   out_tdata);
        end
        if (out_tlast !== exp_beat.last_flag) begin
          errors++;
          $display("%0t: last_in_run expected %0b got %0b", $time, exp_beat.last_flag,
                   out_tlast);
        end
      end
    end
  end

  function automatic int unsigned utf8_len(logic [7:0] b);
    if (b <= 8'h7F) return 1;
    if (b >= 8'hC2 && b <= 8'hDF) return 2;
    if (b >= 8'hE0 && b <= 8'hEF) return 3;
    if (b >= 8'hF0 && b <= 8'hF4) return 4;
    return 0;
  endfunction

  function automatic void predict_clean_bytes(logic [7:0] d, logic eos);
    logic [7:0]  win[0:3];
    clean_beat_t run_q[$];
    clean_beat_t beat;
    int unsigned n;
    int unsigned pos;
    int unsigned len;
    bit          ok;
    n = pend_cnt;
    for (int k = 0; k < 3; k++) win[k] = pend_bytes[k];
    win[n] = d;
    n++;
    pos = 0;
    beat.last_flag = 1'b0;
    while (pos < n) begin
      len = utf8_len(win[pos]);
      if (len != 0 && pos + len > n) break;
      ok = (len != 0);
      for (int k = 1; k < len; k++) begin
        if (win[pos + k][7:6] != 2'b10) ok = 1'b0;
      end
      if (len == 3 && win[pos] == 8'hE0 && win[pos + 1] < 8'hA0) ok = 1'b0;
      if (len == 3 && win[pos] == 8'hED && win[pos + 1] >= 8'hA0) ok = 1'b0;
      if (len == 4 && win[pos] == 8'hF0 && win[pos + 1] < 8'h90) ok = 1'b0;
      if (len == 4 && win[pos] == 8'hF4 && win[pos + 1] > 8'h8F) ok = 1'b0;
      if (!ok) begin
        beat.value = REPL_B0; run_q = {run_q, beat};
        beat.value = REPL_B1; run_q = {run_q, beat};
        beat.value = REPL_B2; run_q = {run_q, beat};
        pos++;
      end else begin
        for (int k = 0; k < len; k++) begin
          beat.value = win[pos + k];
          run_q = {run_q, beat};
        end
        pos += len;
      end
    end
    pend_cnt = n - pos;
    for (int k = 0; k < pend_cnt; k++) pend_bytes[k] = win[pos + k];
    if (eos) pend_cnt = 0;
    if (run_q.size() != 0) run_q[run_q.size() - 1].last_flag = 1'b1;
    clean_q = {clean_q, run_q};
  endfunction

  task automatic send_byte(logic [7:0] d, logic eos);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    predict_clean_bytes(d, eos);
    sent++;
    gap = pick_gap(tx_idle_on);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // send n bytes of w, first byte in the highest used lane
  task automatic send_run(logic [31:0] w, int unsigned n, bit eos_last, bit rnd_eos);
    logic eos;
    for (int i = 0; i < n; i++) begin
      eos = (eos_last && i == n - 1) || (rnd_eos && $urandom_range(0, 23) == 0);
      send_byte(w[8 * (n - 1 - i) +: 8], eos);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (clean_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_lone_bytes();
    send_run(32'h00, 1, 1'b0, 1'b0);
    send_run(32'hC1, 1, 1'b0, 1'b0);
    send_run(32'hF5, 1, 1'b0, 1'b0);
    send_run(32'hFF, 1, 1'b0, 1'b0);
    wait_drained();
  endtask

  task automatic test_good_sequences();
    send_run(32'hC280, 2, 1'b0, 1'b0);
    send_run(32'hE0A080, 3, 1'b0, 1'b0);
    send_run(32'hF48FBFBF, 4, 1'b0, 1'b0);
    wait_drained();
  endtask

  task automatic test_bad_sequences();
    send_run(32'hE09F80, 3, 1'b0, 1'b0);
    send_run(32'hEDA080, 3, 1'b0, 1'b0);
    send_run(32'hF08F8080, 4, 1'b0, 1'b0);
    send_run(32'hF4908080, 4, 1'b0, 1'b0);
    send_run(32'hE2417F, 3, 1'b0, 1'b0);
    wait_drained();
  endtask

  task automatic test_stream_end();
    send_run(32'hF09080, 3, 1'b1, 1'b0);
    send_run(32'h41, 1, 1'b1, 1'b0);
    wait_drained();
  endtask

  function automatic logic [7:0] cont_byte(logic [7:0] lo, logic [7:0] hi);
    return 8'($urandom_range(lo, hi));
  endfunction

  task automatic test_random_text();
    logic [31:0] w;
    logic [7:0]  lead;
    int unsigned n;
    int unsigned kind;
    int unsigned idx;
    bit          drained_once;
    drained_once = 1'b0;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 29) == 0) begin
        tx_idle_on = $urandom_range(0, 2) != 0;
        rx_idle_on = $urandom_range(0, 2) != 0;
      end
      if (!drained_once && sent >= RANDOM_ITEMS / 2) begin
        wait_drained();
        drained_once = 1'b1;
      end
      n = $urandom_range(1, 4);
      case (n)
        1: w = 32'($urandom_range(0, 8'h7F));
        2: w = 32'({8'($urandom_range(8'hC2, 8'hDF)), cont_byte(8'h80, 8'hBF)});
        3: begin
          lead = 8'($urandom_range(8'hE0, 8'hEF));
          if (lead == 8'hE0) w = 32'({lead, cont_byte(8'hA0, 8'hBF)});
          else if (lead == 8'hED) w = 32'({lead, cont_byte(8'h80, 8'h9F)});
          else w = 32'({lead, cont_byte(8'h80, 8'hBF)});
          w = {w[23:0], cont_byte(8'h80, 8'hBF)};
        end
        default: begin
          lead = 8'($urandom_range(8'hF0, 8'hF4));
          if (lead == 8'hF0) w = 32'({lead, cont_byte(8'h90, 8'hBF)});
          else if (lead == 8'hF4) w = 32'({lead, cont_byte(8'h80, 8'h8F)});
          else w = 32'({lead, cont_byte(8'h80, 8'hBF)});
          w = {w[15:0], cont_byte(8'h80, 8'hBF), cont_byte(8'h80, 8'hBF)};
        end
      endcase
      kind = $urandom_range(0, 9);
      if (kind == 6 || kind == 7) begin
        idx = $urandom_range(0, n - 1);
        w[8 * idx +: 8] = 8'($urandom);
      end else if (kind == 8) begin
        w = $urandom;
        n = $urandom_range(1, 4);
      end else if (kind == 9 && n > 1) begin
        idx = $urandom_range(1, n - 1);
        w = w >> (8 * (n - idx));
        n = idx;
      end
      send_run(w, n, 1'b0, 1'b1);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_lone_bytes();
    test_good_sequences();
    test_bad_sequences();
    test_stream_end();
    test_random_text();
    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0 && clean_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/u8s_pkg.sv
rtl/u8s_front.sv
rtl/u8s_queue.sv
rtl/u8s_back.sv
rtl/utf8_stream_sanitizer_core.sv
rtl/u8s_chk.sv
test/utf8_stream_sanitizer_core_test.sv
